// ----- design/lvfs_pkg.sv -----
// Shared constants, codes and control types of the Langevin Verlet step core.
// Used by lvfs_cfg, lvfs_mul and langevin_verlet_feedback_step_core.
`default_nettype none

package lvfs_pkg;

  // Default parameter values.
  localparam int unsigned STATE_BITS_DEF = 48;
  localparam int unsigned COEF_BITS_DEF  = 32;

  // Fixed number formats.
  localparam int unsigned ACC_BITS         = 60;
  localparam int unsigned FRAC_COEF        = 24;
  localparam int unsigned FRAC_STATE       = 32;
  localparam int unsigned MUL_RES_BITS     = 64;
  localparam int unsigned MUL_CHUNK        = 32;
  localparam int unsigned NOISE_BITS       = 32;
  localparam int unsigned NOISE_SCALE_BITS = 8;
  localparam int unsigned COUNT_BITS       = 32;
  localparam int unsigned CFG_INDEX_BITS   = 8;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_STIFFNESS     = 0,
    REG_DAMPING       = 1,
    REG_FEEDBACK_GAIN = 2,
    REG_TIME_STEP     = 3,
    REG_SAVE_INTERVAL = 4,
    REG_LOSS_LIMIT    = 5,
    REG_START_POS     = 6,
    REG_START_VEL     = 7
  } cfg_reg_e;

  // Rounding position of a product: coefficient scale, state scale, or a half kick.
  typedef enum logic [1:0] {
    SH_COEF  = 2'd0,
    SH_STATE = 2'd1,
    SH_HALF  = 2'd2
  } shift_e;

  // Multiply operations of one integration step, in issue order.
  typedef enum logic [2:0] {
    OP_FB    = 3'd0,
    OP_KX1   = 3'd1,
    OP_GV1   = 3'd2,
    OP_KICK1 = 3'd3,
    OP_DRIFT = 3'd4,
    OP_KX2   = 3'd5,
    OP_GV2   = 3'd6,
    OP_KICK2 = 3'd7
  } step_op_e;

  typedef struct packed {
    logic   start;
    shift_e shift;
    logic   wide;   // saturate to 64 bits instead of the acceleration width
  } mul_req_t;

  typedef struct packed {
    logic pos;
    logic vel;
  } cfg_load_t;

endpackage

`default_nettype wire

// ----- design/langevin_verlet_feedback_step_core.sv -----
// Langevin Verlet step core: one trapped-particle step per noise beat, eight products on one
// shared multiplier. A new beat is taken only in the idle state, after the previous step has
// finished and has handed any result to the output register. After halting on loss, each beat
// is still accepted and dropped. Reset loads the register reset values, zero position and
// velocity, step index one; no clearing pass is needed.
`default_nettype none

module langevin_verlet_feedback_step_core #(
  parameter int unsigned STATE_BITS = lvfs_pkg::STATE_BITS_DEF,
  parameter int unsigned COEF_BITS  = lvfs_pkg::COEF_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [lvfs_pkg::NOISE_BITS-1:0]       s_axis_tdata,  // noise_sample
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // step_number, position, velocity, zero padding
  output logic [((lvfs_pkg::COUNT_BITS + 2*STATE_BITS + 7)/8)*8-1:0] m_axis_tdata,
  output logic                                  m_axis_tuser,  // lost
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [lvfs_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [((STATE_BITS > COEF_BITS) ? STATE_BITS : COEF_BITS)-1:0] cfg_data_i
);
  import lvfs_pkg::*;

  localparam int unsigned OPB_BITS = (STATE_BITS > ACC_BITS) ? STATE_BITS : ACC_BITS;
  localparam int unsigned SUM_BITS = ACC_BITS + 3;
  localparam int unsigned SW       = ((STATE_BITS > MUL_RES_BITS) ? STATE_BITS
                                                                   : MUL_RES_BITS) + 1;
  localparam int unsigned OUT_BITS = ((COUNT_BITS + 2*STATE_BITS + 7)/8)*8;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_FINAL = 4'b1000
  } state_e;

  function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [SW-1:0] s);
    if (s[SW-1:STATE_BITS-1] == '0 || s[SW-1:STATE_BITS-1] == '1) begin
      return s[STATE_BITS-1:0];
    end else if (s[SW-1]) begin
      return {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_BITS-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [SUM_BITS-1:0] s);
    if (s[SUM_BITS-1:ACC_BITS-1] == '0 || s[SUM_BITS-1:ACC_BITS-1] == '1) begin
      return s[ACC_BITS-1:0];
    end else if (s[SUM_BITS-1]) begin
      return {1'b1, {(ACC_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_BITS-1){1'b1}}};
    end
  endfunction

  // Configuration.
  logic [COEF_BITS-1:0]  stiffness, damping, feedback_gain, time_step;
  logic [COUNT_BITS-1:0] save_interval;
  logic [STATE_BITS-2:0] loss_limit;
  logic [STATE_BITS-1:0] start_value;
  cfg_load_t             cfg_load;

  lvfs_cfg #(
    .STATE_BITS (STATE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .stiffness_o     (stiffness),
    .damping_o       (damping),
    .feedback_gain_o (feedback_gain),
    .time_step_o     (time_step),
    .save_interval_o (save_interval),
    .loss_limit_o    (loss_limit),
    .start_value_o   (start_value),
    .load_o          (cfg_load)
  );

  // Sequencer and particle state.
  state_e   state_q, state_d;
  step_op_e op_q, op_d;
  logic [COUNT_BITS-1:0] step_q, step_d, save_q, save_d;
  logic     halted_q, halted_d;
  logic     m_valid_q, m_valid_d;

  logic signed [STATE_BITS-1:0] pos_q, vel_q, vh_q, xn_q;
  logic signed [SUM_BITS-1:0]   base_q, sum_q, noise_ext;
  logic signed [ACC_BITS-1:0]   accel_q;
  logic [NOISE_BITS-1:0]        noise_q;
  logic [OUT_BITS-1:0]          m_data_q;
  logic                         m_lost_q;

  // Shared multiplier.
  mul_req_t                       mul_req;
  logic signed [COEF_BITS:0]      mul_a;
  logic signed [OPB_BITS-1:0]     mul_b;
  logic                           mul_done;
  logic signed [MUL_RES_BITS-1:0] mul_res;

  lvfs_mul #(
    .COEF_BITS (COEF_BITS),
    .OPB_BITS  (OPB_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  logic                  in_beat, step_done, fin_go, lost, emit, save_hit, out_free;
  logic [STATE_BITS-1:0] pos_mag;
  logic [COUNT_BITS-1:0] save_inc, interval;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign step_done     = (state_q == ST_WAIT) && mul_done;
  assign noise_ext     = SUM_BITS'($signed({noise_q, {NOISE_SCALE_BITS{1'b0}}}));

  // Operand selection for each product of the step.
  always_comb begin
    mul_req.start = (state_q == ST_ISSUE);
    mul_req.shift = SH_COEF;
    mul_req.wide  = 1'b0;
    mul_a         = $signed({1'b0, time_step});
    mul_b         = OPB_BITS'(accel_q);
    case (op_q)
      OP_FB: begin
        mul_a = $signed({feedback_gain[COEF_BITS-1], feedback_gain});
        mul_b = OPB_BITS'(vel_q);
      end
      OP_KX1: begin
        mul_a = $signed({1'b0, stiffness});
        mul_b = OPB_BITS'(pos_q);
      end
      OP_GV1: begin
        mul_a = $signed({1'b0, damping});
        mul_b = OPB_BITS'(vel_q);
      end
      OP_KICK1, OP_KICK2: begin
        mul_req.shift = SH_HALF;
        mul_req.wide  = 1'b1;
      end
      OP_DRIFT: begin
        mul_b         = OPB_BITS'(vh_q);
        mul_req.shift = SH_STATE;
        mul_req.wide  = 1'b1;
      end
      OP_KX2: begin
        mul_a = $signed({1'b0, stiffness});
        mul_b = OPB_BITS'(xn_q);
      end
      OP_GV2: begin
        mul_a = $signed({1'b0, damping});
        mul_b = OPB_BITS'(vh_q);
      end
      default: ;
    endcase
  end

  // End-of-step bookkeeping: loss check against the new position, save counter.
  assign pos_mag  = pos_q[STATE_BITS-1] ? STATE_BITS'(-pos_q) : STATE_BITS'(pos_q);
  assign lost     = pos_mag > {1'b0, loss_limit};
  assign save_inc = save_q + COUNT_BITS'(1);
  assign interval = (save_interval == '0) ? COUNT_BITS'(1) : save_interval;
  assign save_hit = save_inc >= interval;
  assign emit     = lost || save_hit;
  assign out_free = !m_valid_q || m_axis_tready;
  assign fin_go   = (state_q == ST_FINAL) && (!emit || out_free);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    step_d    = step_q;
    save_d    = save_q;
    halted_d  = halted_q;
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_beat && !halted_q) begin
          state_d = ST_ISSUE;
          op_d    = OP_FB;
        end
      end
      ST_ISSUE: state_d = ST_WAIT;
      ST_WAIT: begin
        if (mul_done) begin
          if (op_q == OP_KICK2) begin
            state_d = ST_FINAL;
          end else begin
            state_d = ST_ISSUE;
            op_d    = step_op_e'(3'(op_q + 3'd1));
          end
        end
      end
      ST_FINAL: begin
        if (fin_go) begin
          state_d = ST_IDLE;
          step_d  = step_q + COUNT_BITS'(1);
          if (lost) begin
            halted_d = 1'b1;
          end else begin
            save_d = save_hit ? '0 : save_inc;
          end
          if (emit) m_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_FB;
      step_q    <= COUNT_BITS'(1);
      save_q    <= '0;
      halted_q  <= 1'b0;
      m_valid_q <= 1'b0;
      pos_q     <= '0;
      vel_q     <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      step_q    <= step_d;
      save_q    <= save_d;
      halted_q  <= halted_d;
      m_valid_q <= m_valid_d;
      if (cfg_load.pos) begin
        pos_q <= start_value;
      end else if (step_done && op_q == OP_KICK2) begin
        pos_q <= xn_q;
      end
      if (cfg_load.vel) begin
        vel_q <= start_value;
      end else if (step_done && op_q == OP_KICK2) begin
        vel_q <= sat_state(SW'(vh_q) + SW'(mul_res));
      end
    end
  end

  // Intermediate values of the step, written as each product comes back.
  always_ff @(posedge clk_i) begin
    if (in_beat && !halted_q) noise_q <= s_axis_tdata;
    if (step_done) begin
      case (op_q)
        OP_FB:          base_q  <= noise_ext + SUM_BITS'(mul_res);
        OP_KX1, OP_KX2: sum_q   <= base_q - SUM_BITS'(mul_res);
        OP_GV1, OP_GV2: accel_q <= sat_acc(sum_q - SUM_BITS'(mul_res));
        OP_KICK1:       vh_q    <= sat_state(SW'(vel_q) + SW'(mul_res));
        OP_DRIFT:       xn_q    <= sat_state(SW'(pos_q) + SW'(mul_res));
        default: ;
      endcase
    end
    if (fin_go && emit) begin
      m_data_q <= OUT_BITS'({vel_q, pos_q, step_q});
      m_lost_q <= lost;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_lost_q;

endmodule

`default_nettype wire

// ----- design/lvfs_cfg.sv -----
// Configuration register file of the Langevin Verlet step core.
// Depends on lvfs_pkg for register indexes and the load strobe type.
`default_nettype none

module lvfs_cfg #(
  parameter int unsigned STATE_BITS = lvfs_pkg::STATE_BITS_DEF,
  parameter int unsigned COEF_BITS  = lvfs_pkg::COEF_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [lvfs_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [((STATE_BITS > COEF_BITS) ? STATE_BITS : COEF_BITS)-1:0] cfg_data_i,
  output logic [COEF_BITS-1:0]                  stiffness_o,
  output logic [COEF_BITS-1:0]                  damping_o,
  output logic [COEF_BITS-1:0]                  feedback_gain_o,
  output logic [COEF_BITS-1:0]                  time_step_o,
  output logic [lvfs_pkg::COUNT_BITS-1:0]       save_interval_o,
  output logic [STATE_BITS-2:0]                 loss_limit_o,
  output logic [STATE_BITS-1:0]                 start_value_o,
  output lvfs_pkg::cfg_load_t                   load_o
);
  import lvfs_pkg::*;

  logic [COEF_BITS-1:0]  stiffness_q, damping_q, feedback_gain_q, time_step_q;
  logic [COUNT_BITS-1:0] save_interval_q;
  logic [STATE_BITS-2:0] loss_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiffness_q     <= '0;
      damping_q       <= '0;
      feedback_gain_q <= '0;
      time_step_q     <= '0;
      save_interval_q <= COUNT_BITS'(1);
      loss_limit_q    <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STIFFNESS:     stiffness_q     <= cfg_data_i[COEF_BITS-1:0];
        REG_DAMPING:       damping_q       <= cfg_data_i[COEF_BITS-1:0];
        REG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data_i[COEF_BITS-1:0];
        REG_TIME_STEP:     time_step_q     <= cfg_data_i[COEF_BITS-1:0];
        REG_SAVE_INTERVAL: save_interval_q <= cfg_data_i[COUNT_BITS-1:0];
        REG_LOSS_LIMIT:    loss_limit_q    <= cfg_data_i[STATE_BITS-2:0];
        default: ;
      endcase
    end
  end

  // The start values are not kept: a write loads the particle state directly.
  assign start_value_o = cfg_data_i[STATE_BITS-1:0];
  assign load_o.pos    = cfg_valid_i && (cfg_index_i == REG_START_POS);
  assign load_o.vel    = cfg_valid_i && (cfg_index_i == REG_START_VEL);

  assign stiffness_o     = stiffness_q;
  assign damping_o       = damping_q;
  assign feedback_gain_o = feedback_gain_q;
  assign time_step_o     = time_step_q;
  assign save_interval_o = save_interval_q;
  assign loss_limit_o    = loss_limit_q;

endmodule

`default_nettype wire

// ----- design/lvfs_mul.sv -----
// Shared multiply unit: sign-magnitude product built from 32x32 partial products,
// then rounded half away from zero and saturated. Depends on lvfs_pkg.
`default_nettype none

module lvfs_mul #(
  parameter int unsigned COEF_BITS = lvfs_pkg::COEF_BITS_DEF,
  parameter int unsigned OPB_BITS  = lvfs_pkg::ACC_BITS
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  lvfs_pkg::mul_req_t                          req_i,
  input  logic signed [COEF_BITS:0]                   a_i,
  input  logic signed [OPB_BITS-1:0]                  b_i,
  output logic                                        done_o,
  output logic signed [lvfs_pkg::MUL_RES_BITS-1:0]    res_o
);
  import lvfs_pkg::*;

  localparam int unsigned A_CH = (COEF_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int unsigned B_CH = (OPB_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int unsigned AW   = A_CH * MUL_CHUNK;
  localparam int unsigned BW   = B_CH * MUL_CHUNK;
  localparam int unsigned PW   = AW + BW;
  localparam int unsigned PW1  = PW + 1;
  localparam int unsigned IAW  = (A_CH > 1) ? $clog2(A_CH) : 1;
  localparam int unsigned IBW  = (B_CH > 1) ? $clog2(B_CH) : 1;

  typedef enum logic [2:0] {
    MS_IDLE = 3'b001,
    MS_MUL  = 3'b010,
    MS_RND  = 3'b100
  } mul_state_e;

  mul_state_e state_q, state_d;
  logic       done_q, done_d;
  logic [IAW-1:0] ia_q, ia_d;
  logic [IBW-1:0] ib_q, ib_d;

  logic [AW-1:0] a_mag_q;
  logic [BW-1:0] b_mag_q;
  logic [PW-1:0] acc_q;
  logic          neg_q;
  shift_e        shift_q;
  logic          wide_q;
  logic signed [MUL_RES_BITS-1:0] res_q, res_d;

  logic signed [COEF_BITS:0]     a_abs;
  logic signed [OPB_BITS-1:0]    b_abs;
  logic [2*MUL_CHUNK-1:0]        pp;
  logic [5:0]                    rnd_bits;
  logic [PW1-1:0]                rnd_sum, rnd_val;
  logic [MUL_RES_BITS-1:0]       lim, mag;
  logic                          last_pp;

  assign a_abs   = a_i[COEF_BITS] ? -a_i : a_i;
  assign b_abs   = b_i[OPB_BITS-1] ? -b_i : b_i;
  assign pp      = a_mag_q[ia_q*MUL_CHUNK +: MUL_CHUNK] * b_mag_q[ib_q*MUL_CHUNK +: MUL_CHUNK];
  assign last_pp = (ia_q == IAW'(A_CH - 1)) && (ib_q == IBW'(B_CH - 1));

  always_comb begin
    case (shift_q)
      SH_COEF:  rnd_bits = 6'(FRAC_COEF);
      SH_STATE: rnd_bits = 6'(FRAC_STATE);
      SH_HALF:  rnd_bits = 6'(FRAC_STATE + 1);
      default:  rnd_bits = 6'(FRAC_COEF);
    endcase
    rnd_sum = {1'b0, acc_q} + (PW1'(1) << (rnd_bits - 6'd1));
    rnd_val = rnd_sum >> rnd_bits;
    lim = wide_q ? (MUL_RES_BITS'(1) << (MUL_RES_BITS - 1))
                 : (MUL_RES_BITS'(1) << (ACC_BITS - 1));
    // A negative result reaches one step further than a positive one.
    if (!neg_q) lim = lim - MUL_RES_BITS'(1);
    mag   = (rnd_val > PW1'(lim)) ? lim : rnd_val[MUL_RES_BITS-1:0];
    res_d = neg_q ? -$signed(mag) : $signed(mag);
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    ia_d    = ia_q;
    ib_d    = ib_q;
    case (state_q)
      MS_IDLE: begin
        if (req_i.start) begin
          state_d = MS_MUL;
          ia_d    = '0;
          ib_d    = '0;
        end
      end
      MS_MUL: begin
        if (last_pp) begin
          state_d = MS_RND;
        end else if (ib_q == IBW'(B_CH - 1)) begin
          ib_d = '0;
          ia_d = ia_q + IAW'(1);
        end else begin
          ib_d = ib_q + IBW'(1);
        end
      end
      MS_RND: begin
        state_d = MS_IDLE;
        done_d  = 1'b1;
      end
      default: state_d = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MS_IDLE;
      done_q  <= 1'b0;
      ia_q    <= '0;
      ib_q    <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      ia_q    <= ia_d;
      ib_q    <= ib_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == MS_IDLE && req_i.start) begin
      a_mag_q <= AW'(a_abs[COEF_BITS-1:0]);
      b_mag_q <= BW'(unsigned'(b_abs));
      neg_q   <= a_i[COEF_BITS] ^ b_i[OPB_BITS-1];
      shift_q <= req_i.shift;
      wide_q  <= req_i.wide;
      acc_q   <= '0;
    end else if (state_q == MS_MUL) begin
      acc_q <= acc_q + (PW'(pp) << (MUL_CHUNK * (ia_q + ib_q)));
    end
    if (state_q == MS_RND) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ----- bench/lvfs_step_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the Langevin Verlet step core: watches the config, noise and result channels.
// Keeps its own copy of the particle state, predicts each result and compares beat by beat.
// Depends on lvfs_pkg for the register codes and the fixed-point widths.

module lvfs_step_checker
  import lvfs_pkg::*;
#(
  parameter int unsigned STATE_W = STATE_BITS_DEF,
  parameter int unsigned CFG_W   = (STATE_BITS_DEF > COEF_BITS_DEF) ? STATE_BITS_DEF
                                                                    : COEF_BITS_DEF,
  parameter int unsigned RES_W   = ((COUNT_BITS + 2*STATE_BITS_DEF + 7)/8)*8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      noise_valid_i,
  input  logic                      noise_ready_i,
  input  logic [NOISE_BITS-1:0]     noise_i,
  input  logic                      res_valid_i,
  input  logic                      res_ready_i,
  input  logic [RES_W-1:0]          res_data_i,
  input  logic                      res_lost_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  output int                        mismatches_o,
  output int                        pending_o
);

  typedef struct packed {
    logic [COUNT_BITS-1:0] step;
    logic [STATE_W-1:0]    pos;
    logic [STATE_W-1:0]    vel;
    logic                  lost;
  } particle_sample_t;

  // Configuration copy.
  logic [31:0]            stiffness_q   = '0;
  logic [31:0]            damping_q     = '0;
  logic signed [31:0]     gain_q        = '0;
  logic [31:0]            dt_q          = '0;
  logic [31:0]            interval_q    = 32'd1;
  logic [STATE_W-2:0]     loss_limit_q  = '1;

  // Particle state.
  logic signed [STATE_W-1:0] pos_q      = '0;
  logic signed [STATE_W-1:0] vel_q      = '0;
  logic [COUNT_BITS-1:0]     step_q     = 1;
  logic [31:0]               save_cnt_q = '0;
  logic                      halted_q   = 1'b0;

  particle_sample_t expected_samples[$];
  int fail_count = 0;
  int waiting    = 0;

  assign mismatches_o = fail_count;
  assign pending_o    = waiting;

  // Product of a and b over 2^sh, rounded half away from zero, saturated to signed w bits.
  function automatic logic signed [63:0] round_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int unsigned sh,
                                                   input int unsigned w);
    logic         neg;
    logic [63:0]  ma, mb;
    logic [127:0] prod, lim;
    neg  = a[63] != b[63];
    ma   = a[63] ? -a : a;
    mb   = b[63] ? -b : b;
    prod = {64'd0, ma} * {64'd0, mb};
    prod = (prod + (128'd1 << (sh - 1))) >> sh;
    lim  = (128'd1 << (w - 1)) - (neg ? 128'd0 : 128'd1);
    if (prod > lim) prod = lim;
    return neg ? -prod[63:0] : prod[63:0];
  endfunction

  function automatic logic signed [63:0] clamp_to(input logic signed [64:0] v,
                                                  input int unsigned w);
    logic signed [64:0] hi, lo;
    hi = (65'sd1 <<< (w - 1)) - 65'sd1;
    lo = -hi - 65'sd1;
    if (v > hi) return hi[63:0];
    if (v < lo) return lo[63:0];
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input int unsigned w);
    logic signed [64:0] s;
    s = a + b;
    return clamp_to(s, w);
  endfunction

  function automatic logic signed [63:0] trap_accel(input logic signed [63:0] x,
                                                    input logic signed [63:0] v,
                                                    input logic signed [63:0] nz,
                                                    input logic signed [63:0] fb);
    logic signed [63:0] kx, gv;
    logic signed [64:0] sum;
    kx  = round_mul(stiffness_q, x, FRAC_COEF, ACC_BITS);
    gv  = round_mul(damping_q, v, FRAC_COEF, ACC_BITS);
    sum = nz + fb - kx - gv;
    return clamp_to(sum, ACC_BITS);
  endfunction

  task automatic reset_particle();
    stiffness_q  = '0;
    damping_q    = '0;
    gain_q       = '0;
    dt_q         = '0;
    interval_q   = 32'd1;
    loss_limit_q = '1;
    pos_q        = '0;
    vel_q        = '0;
    step_q       = 1;
    save_cnt_q   = '0;
    halted_q     = 1'b0;
    expected_samples.delete();
  endtask

  task automatic apply_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_W-1:0] data);
    case (idx)
      REG_STIFFNESS:     stiffness_q  = data[31:0];
      REG_DAMPING:       damping_q    = data[31:0];
      REG_FEEDBACK_GAIN: gain_q       = data[31:0];
      REG_TIME_STEP:     dt_q         = data[31:0];
      REG_SAVE_INTERVAL: interval_q   = data[31:0];
      REG_LOSS_LIMIT:    loss_limit_q = data[STATE_W-2:0];
      REG_START_POS:     pos_q        = data[STATE_W-1:0];
      REG_START_VEL:     vel_q        = data[STATE_W-1:0];
      default: ;
    endcase
  endtask

  // One split velocity-Verlet step; both kicks use the start velocity for the feedback force.
  task automatic advance_particle(input logic [NOISE_BITS-1:0] sample);
    logic signed [63:0]     x, v, dt, nz, fb, a1, vh, xn, a2, vn;
    logic signed [31:0]     ns;
    logic [63:0]            mag;
    logic [31:0]            interval;
    logic                   lost, emit;
    particle_sample_t       s;
    if (halted_q) return;
    x  = pos_q;
    v  = vel_q;
    dt = {32'd0, dt_q};
    ns = sample;
    nz = ns;
    nz = nz * 64'sd256;
    fb = round_mul(gain_q, v, FRAC_COEF, ACC_BITS);
    a1 = trap_accel(x, v, nz, fb);
    vh = sat_add(v, round_mul(dt, a1, FRAC_STATE + 1, MUL_RES_BITS), STATE_W);
    xn = sat_add(x, round_mul(dt, vh, FRAC_STATE, MUL_RES_BITS), STATE_W);
    a2 = trap_accel(xn, vh, nz, fb);
    vn = sat_add(vh, round_mul(dt, a2, FRAC_STATE + 1, MUL_RES_BITS), STATE_W);
    s.step = step_q;
    s.pos  = xn[STATE_W-1:0];
    s.vel  = vn[STATE_W-1:0];
    pos_q  = xn[STATE_W-1:0];
    vel_q  = vn[STATE_W-1:0];
    step_q = step_q + 1;
    mag    = xn[63] ? -xn : xn;
    lost   = mag > {{(64-STATE_W+1){1'b0}}, loss_limit_q};
    if (lost) begin
      halted_q = 1'b1;
      emit     = 1'b1;
    end else begin
      interval   = (interval_q == 0) ? 32'd1 : interval_q;
      save_cnt_q = save_cnt_q + 1;
      emit       = save_cnt_q >= interval;
      if (emit) save_cnt_q = '0;
    end
    s.lost = lost;
    if (emit) expected_samples.push_back(s);
  endtask

  task automatic check_sample(input logic [RES_W-1:0] data, input logic lost);
    particle_sample_t got, want;
    got.step = data[COUNT_BITS-1:0];
    got.pos  = data[COUNT_BITS +: STATE_W];
    got.vel  = data[COUNT_BITS + STATE_W +: STATE_W];
    got.lost = lost;
    if (expected_samples.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("checker: result beat with nothing predicted: step=%0d pos=%h vel=%h lost=%b",
                 got.step, got.pos, got.vel, got.lost);
      return;
    end
    want = expected_samples.pop_front();
    if (got.step !== want.step || got.pos !== want.pos || got.vel !== want.vel ||
        got.lost !== want.lost) begin
      fail_count++;
      if (fail_count <= 10)
        $display("checker: mismatch at %0t: expected step=%0d pos=%h vel=%h lost=%b, %s",
                 $realtime, want.step, want.pos, want.vel, want.lost,
                 $sformatf("got step=%0d pos=%h vel=%h lost=%b",
                           got.step, got.pos, got.vel, got.lost));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_particle();
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_write(cfg_index_i, cfg_data_i);
      if (noise_valid_i && noise_ready_i) advance_particle(noise_i);
      if (res_valid_i && res_ready_i) check_sample(res_data_i, res_lost_i);
    end
    waiting = expected_samples.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Top of the bench for langevin_verlet_feedback_step_core: clock, reset, stimulus and verdict.
// Depends on lvfs_pkg, the core and lvfs_step_checker, which predicts and compares results.

module tb;
  import lvfs_pkg::*;

  localparam int unsigned STATE_W = STATE_BITS_DEF;
  localparam int unsigned CFG_W   = (STATE_BITS_DEF > COEF_BITS_DEF) ? STATE_BITS_DEF
                                                                     : COEF_BITS_DEF;
  localparam int unsigned RES_W   = ((COUNT_BITS + 2*STATE_BITS_DEF + 7)/8)*8;
  localparam int QUIET_CYCLES     = 60;   // room for a last step that emits nothing to finish
  localparam int RANDOM_ITEMS     = 990;

  localparam logic [CFG_W-1:0] POS_MAX    = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic [CFG_W-1:0] POS_MIN    = {1'b1, {(STATE_W-1){1'b0}}};
  localparam logic [CFG_W-1:0] UNIT_POS   = 48'h0001_0000_0000;
  localparam logic [CFG_W-1:0] UNIT_NEG   = 48'hFFFF_0000_0000;
  localparam logic [CFG_W-1:0] COEF_MAX   = 48'h0000_FFFF_FFFF;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [NOISE_BITS-1:0]     s_axis_tdata  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [RES_W-1:0]          m_axis_tdata;
  logic                      m_axis_tuser;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i   = '0;
  logic [CFG_W-1:0]          cfg_data_i    = '0;

  int mismatches;
  int pending;
  int burst_left = 1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  langevin_verlet_feedback_step_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  lvfs_step_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .noise_valid_i (s_axis_tvalid),
    .noise_ready_i (s_axis_tready),
    .noise_i       (s_axis_tdata),
    .res_valid_i   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_data_i    (m_axis_tdata),
    .res_lost_i    (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Sends one noise beat; the sender runs in bursts with gaps of random length in between.
  task automatic send_noise(input logic [NOISE_BITS-1:0] sample);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      pause_sender($urandom_range(1, ($urandom_range(0, 3) == 0) ? 50 : 6));
    end
  endtask

  // Waits until every predicted result is in, then lets a step that emits nothing finish.
  task automatic settle();
    if (s_axis_tvalid) pause_sender(1);
    while (pending != 0) @(negedge clk_i);
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_batch(input int n);
    repeat (n) send_noise($urandom);
    settle();
  endtask

  // Receiver: free-running, random, mostly-ready and fully stalled stretches.
  initial begin : result_sink
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = (mode == 3) ? $urandom_range(1, 40) : $urandom_range(1, 120);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= 1'b0;
        endcase
      end
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int          sent;
    int          n;
    logic [63:0] r;
    logic [31:0] interval;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration with a zero loss limit: nothing moves, so nothing is lost.
    write_reg(REG_LOSS_LIMIT, '0);
    send_noise('0);
    send_noise(32'h7FFF_FFFF);
    send_noise(32'h8000_0000);
    send_noise(32'hFFFF_FFFF);
    send_noise(32'h0000_0001);
    settle();

    // Position saturates high and lands exactly on the loss limit, which is not a loss.
    write_reg(REG_LOSS_LIMIT, POS_MAX);
    write_reg(REG_TIME_STEP, COEF_MAX);
    write_reg(REG_START_POS, POS_MAX);
    write_reg(REG_START_VEL, POS_MAX);
    send_noise(32'h7FFF_FFFF);
    send_noise(32'h7FFF_FFFF);
    settle();

    // Coefficient extremes, each from a freshly loaded small state.
    write_reg(8'($urandom_range(8, 255)), CFG_W'({$urandom, $urandom}));
    write_reg(REG_STIFFNESS, COEF_MAX);
    write_reg(REG_START_POS, UNIT_POS);
    write_reg(REG_START_VEL, '0);
    send_batch(1);
    write_reg(REG_STIFFNESS, '0);
    write_reg(REG_DAMPING, COEF_MAX);
    write_reg(REG_START_POS, '0);
    write_reg(REG_START_VEL, UNIT_POS);
    send_batch(1);
    write_reg(REG_DAMPING, '0);
    write_reg(REG_FEEDBACK_GAIN, 48'h0000_8000_0000);
    write_reg(REG_START_VEL, UNIT_POS);
    send_batch(1);
    write_reg(REG_FEEDBACK_GAIN, 48'h0000_7FFF_FFFF);
    write_reg(REG_START_VEL, UNIT_NEG);
    send_batch(1);

    // Save interval handling, including lowering it below the running count.
    write_reg(REG_FEEDBACK_GAIN, '0);
    write_reg(REG_TIME_STEP, 48'h0000_4000_0000);
    write_reg(REG_START_POS, '0);
    write_reg(REG_START_VEL, '0);
    write_reg(REG_SAVE_INTERVAL, CFG_W'(3));
    send_batch(4);
    write_reg(REG_SAVE_INTERVAL, CFG_W'(5));
    send_batch(2);
    write_reg(REG_SAVE_INTERVAL, CFG_W'(2));
    send_batch(1);
    write_reg(REG_SAVE_INTERVAL, CFG_W'(0));
    send_batch(1);
    write_reg(REG_SAVE_INTERVAL, COEF_MAX);
    send_batch(2);
    write_reg(REG_SAVE_INTERVAL, CFG_W'(1));
    send_batch(1);

    // Random phases with a stable, damped trap so the particle stays well inside the limit.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_reg(REG_STIFFNESS,
                {16'($urandom), 32'($urandom_range(32'h0040_0000, 32'h0400_0000))});
      write_reg(REG_DAMPING,
                {16'($urandom), 32'($urandom_range(32'h0080_0000, 32'h0100_0000))});
      write_reg(REG_FEEDBACK_GAIN,
                {16'($urandom), 32'($urandom_range(0, 32'h0140_0000)) - 32'h0100_0000});
      write_reg(REG_TIME_STEP, {16'($urandom), 32'($urandom_range(0, 32'h8000_0000))});
      case ($urandom_range(0, 7))
        0:       interval = 0;
        1:       interval = $urandom_range(5, 12);
        default: interval = $urandom_range(1, 4);
      endcase
      write_reg(REG_SAVE_INTERVAL, {16'($urandom), interval});
      r = {$urandom, $urandom};
      write_reg(REG_LOSS_LIMIT, {r[47], 1'b1, r[45:0]});
      if ($urandom_range(0, 3) != 0) begin
        r = {$urandom, $urandom};
        write_reg(REG_START_POS, {{(STATE_W-43){r[42]}}, r[42:0]});
        r = {$urandom, $urandom};
        write_reg(REG_START_VEL, {{(STATE_W-43){r[42]}}, r[42:0]});
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(8'($urandom_range(8, 255)), CFG_W'({$urandom, $urandom}));
      n = $urandom_range(20, 80);
      send_batch(n);
      sent += n;
    end

    // The particle leaves the trap through negative saturation; later beats are dropped.
    write_reg(REG_STIFFNESS, '0);
    write_reg(REG_DAMPING, '0);
    write_reg(REG_FEEDBACK_GAIN, '0);
    write_reg(REG_TIME_STEP, COEF_MAX);
    write_reg(REG_SAVE_INTERVAL, CFG_W'(4));
    write_reg(REG_LOSS_LIMIT, POS_MAX);
    write_reg(REG_START_POS, POS_MIN);
    write_reg(REG_START_VEL, POS_MIN);
    repeat (4) send_noise($urandom);
    settle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
